// File: design/uoas_pkg.sv
`timescale 1ns / 1ps
package uoas_pkg;

   // field and register widths
   localparam int THRESH_W = 10;
   localparam int MS_W     = 16;
   localparam int WIDTH_W  = 16;
   localparam int DIST_W   = 19;
   localparam int MUL_W    = 11;
   localparam int PROD_W   = WIDTH_W + MUL_W;
   localparam int FRAC_W   = 8;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   // 1124/65536 cm per microsecond of round trip
   localparam logic [MUL_W-1:0] DIST_MUL = MUL_W'(1124);

   // motor line patterns: bit0 lf, bit1 lr, bit2 rf, bit3 rr
   localparam logic [3:0] LINES_STOP       = 4'h0;
   localparam logic [3:0] LINES_FORWARD    = 4'h5;
   localparam logic [3:0] LINES_TURN_RIGHT = 4'h9;

   // register indexes
   localparam logic [1:0] REG_THRESHOLD = 2'd0;
   localparam logic [1:0] REG_STOP      = 2'd1;
   localparam logic [1:0] REG_TURN      = 2'd2;
   localparam logic [1:0] REG_PAUSE     = 2'd3;

   // register reset values
   localparam logic [THRESH_W-1:0] THRESH_RST = THRESH_W'(30);
   localparam logic [MS_W-1:0]     STOP_RST   = MS_W'(500);
   localparam logic [MS_W-1:0]     TURN_RST   = MS_W'(700);
   localparam logic [MS_W-1:0]     PAUSE_RST  = MS_W'(100);

   typedef struct packed {
      logic [THRESH_W-1:0] threshold_cm;
      logic [MS_W-1:0]     stop_ms;
      logic [MS_W-1:0]     turn_ms;
      logic [MS_W-1:0]     pause_ms;
   } cfg_type;

   typedef struct packed {
      logic              trigger;
      logic              left_forward;
      logic              left_reverse;
      logic              right_forward;
      logic              right_reverse;
      logic              measure_done;
      logic [DIST_W-1:0] distance_q8;
   } rsp_type;

endpackage

// File: design/uoas_req_if.sv
`timescale 1ns / 1ps
interface uoas_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink (input valid, input echo_level, output ready);
endinterface

// File: design/uoas_rsp_if.sv
`timescale 1ns / 1ps
interface uoas_rsp_if;
   import uoas_pkg::*;

   logic              valid;
   logic              ready;
   logic              trigger;
   logic              left_forward;
   logic              left_reverse;
   logic              right_forward;
   logic              right_reverse;
   logic              measure_done;
   logic [DIST_W-1:0] distance_q8;

   modport source (output valid, output trigger, output left_forward, output left_reverse,
                   output right_forward, output right_reverse, output measure_done,
                   output distance_q8, input ready);
   modport sink (input valid, input trigger, input left_forward, input left_reverse,
                 input right_forward, input right_reverse, input measure_done,
                 input distance_q8, output ready);
endinterface

// File: design/uoas_csr.sv
`timescale 1ns / 1ps
module uoas_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [uoas_pkg::ADDR_W-1:0]   paddr,
   input  logic [uoas_pkg::DATA_W-1:0]   pwdata,
   output logic [uoas_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output uoas_pkg::cfg_type             cfg
);
   import uoas_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_THRESHOLD: cfg_in.threshold_cm = pwdata[THRESH_W-1:0];
            REG_STOP:      cfg_in.stop_ms      = pwdata[MS_W-1:0];
            REG_TURN:      cfg_in.turn_ms      = pwdata[MS_W-1:0];
            REG_PAUSE:     cfg_in.pause_ms     = pwdata[MS_W-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_cm <= THRESH_RST;
         cfg_ff.stop_ms      <= STOP_RST;
         cfg_ff.turn_ms      <= TURN_RST;
         cfg_ff.pause_ms     <= PAUSE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         REG_THRESHOLD: prdata = DATA_W'(cfg_ff.threshold_cm);
         REG_STOP:      prdata = DATA_W'(cfg_ff.stop_ms);
         REG_TURN:      prdata = DATA_W'(cfg_ff.turn_ms);
         REG_PAUSE:     prdata = DATA_W'(cfg_ff.pause_ms);
         default:       prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

// File: design/uoas_core.sv
`timescale 1ns / 1ps
module uoas_core #(
   parameter int TICKS_PER_MS = 1000,
   parameter int TRIG_LOW_US  = 2,
   parameter int TRIG_HIGH_US = 10,
   parameter int MICRO_W      = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic              echo_level,
   input  uoas_pkg::cfg_type cfg,
   output uoas_pkg::rsp_type result
);
   import uoas_pkg::*;

   typedef enum logic [2:0] {
      PH_TRIG_LOW  = 3'd0,
      PH_TRIG_HIGH = 3'd1,
      PH_WAIT_RISE = 3'd2,
      PH_MEASURE   = 3'd3,
      PH_STOP      = 3'd4,
      PH_TURN      = 3'd5,
      PH_PAUSE     = 3'd6
   } phase_type;

   phase_type           phase_ff, phase_in;
   logic [MICRO_W-1:0]  micro_ff, micro_in;
   logic [MS_W-1:0]     milli_ff, milli_in;
   logic [WIDTH_W-1:0]  width_ff, width_in;
   logic [3:0]          lines_ff, lines_in;
   logic [DIST_W-1:0]   dist_ff, dist_in;
   rsp_type             result_ff, result_in;
   logic                done;

   logic [MICRO_W-1:0]  micro_inc;
   logic [MICRO_W-1:0]  wait_micro;
   logic [MS_W-1:0]     wait_milli;
   logic [MS_W-1:0]     wait_limit;
   logic                wait_end;
   logic [PROD_W-1:0]   prod;
   logic [DIST_W-1:0]   dist_calc;
   logic                go_forward;

   // shared millisecond wait counter
   assign micro_inc = micro_ff + MICRO_W'(1);
   always_comb begin
      case (phase_ff)
         PH_STOP: wait_limit = cfg.stop_ms;
         PH_TURN: wait_limit = cfg.turn_ms;
         default: wait_limit = cfg.pause_ms;
      endcase
      if (micro_inc >= MICRO_W'(TICKS_PER_MS)) begin
         wait_micro = '0;
         wait_milli = milli_ff + MS_W'(1);
      end else begin
         wait_micro = micro_inc;
         wait_milli = milli_ff;
      end
      wait_end = (wait_milli >= wait_limit);
   end

   // distance from echo width and forward decision
   assign prod       = PROD_W'(width_ff) * PROD_W'(DIST_MUL);
   assign dist_calc  = prod[PROD_W-1:FRAC_W];
   assign go_forward = dist_calc > DIST_W'({cfg.threshold_cm, {FRAC_W{1'b0}}});

   // phase sequencing
   always_comb begin
      phase_in = phase_ff;
      micro_in = micro_ff;
      milli_in = milli_ff;
      width_in = width_ff;
      lines_in = lines_ff;
      dist_in  = dist_ff;
      done     = 1'b0;
      unique case (phase_ff) inside
         PH_TRIG_LOW: begin
            micro_in = micro_inc;
            if (micro_inc >= MICRO_W'(TRIG_LOW_US)) begin
               phase_in = PH_TRIG_HIGH;
               micro_in = '0;
               milli_in = '0;
            end
         end
         PH_TRIG_HIGH: begin
            micro_in = micro_inc;
            if (micro_inc >= MICRO_W'(TRIG_HIGH_US)) begin
               phase_in = PH_WAIT_RISE;
               micro_in = '0;
               milli_in = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (echo_level) begin
               width_in = WIDTH_W'(1);
               phase_in = PH_MEASURE;
               micro_in = '0;
               milli_in = '0;
            end
         end
         PH_MEASURE: begin
            if (echo_level) begin
               if (width_ff != {WIDTH_W{1'b1}}) begin
                  width_in = width_ff + WIDTH_W'(1);
               end
            end else begin
               dist_in  = dist_calc;
               done     = 1'b1;
               micro_in = '0;
               milli_in = '0;
               if (go_forward) begin
                  lines_in = LINES_FORWARD;
                  phase_in = PH_PAUSE;
               end else begin
                  lines_in = LINES_STOP;
                  phase_in = PH_STOP;
               end
            end
         end
         PH_STOP, PH_TURN, PH_PAUSE: begin
            micro_in = wait_micro;
            milli_in = wait_milli;
            if (wait_end) begin
               micro_in = '0;
               milli_in = '0;
               if (phase_ff == PH_STOP) begin
                  lines_in = LINES_TURN_RIGHT;
                  phase_in = PH_TURN;
               end else if (phase_ff == PH_TURN) begin
                  lines_in = LINES_STOP;
                  phase_in = PH_PAUSE;
               end else begin
                  phase_in = PH_TRIG_LOW;
               end
            end
         end
         default: begin
            phase_in = PH_TRIG_LOW;
            micro_in = '0;
            milli_in = '0;
         end
      endcase
   end

   // trigger and motor lines from the state at the start of the tick, done and distance from its update
   always_comb begin
      result_in.trigger       = (phase_ff == PH_TRIG_HIGH);
      result_in.left_forward  = lines_ff[0];
      result_in.left_reverse  = lines_ff[1];
      result_in.right_forward = lines_ff[2];
      result_in.right_reverse = lines_ff[3];
      result_in.measure_done  = done;
      result_in.distance_q8   = dist_in;
   end

   // phase state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TRIG_LOW;
         micro_ff <= '0;
         milli_ff <= '0;
         width_ff <= '0;
         lines_ff <= LINES_STOP;
         dist_ff  <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         micro_ff  <= micro_in;
         milli_ff  <= milli_in;
         width_ff  <= width_in;
         lines_ff  <= lines_in;
         dist_ff   <= dist_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// File: design/ultrasonic_obstacle_avoid_sequencer.sv
`timescale 1ns / 1ps
// channel   dir  handshake       payload
// req       in   valid / ready   echo_level
// rsp       out  valid / ready   trigger, motor lines, measure_done, distance_q8
// csr       in   apb psel/pen    threshold_cm, stop_ms, turn_ms, pause_ms
//
// one request per clock while rsp is not stalled; its result is registered in an input register
// and then a result register around one tick of logic.
// the critical path is the 16x11 distance multiply and threshold compare.
// reset is synchronous and active high and returns the valid, core state and config registers to their defaults.
// a stalled rsp holds the result; req keeps accepting while the input stage can move.
module ultrasonic_obstacle_avoid_sequencer #(
   parameter int TICKS_PER_MS = 1000,
   parameter int TRIG_LOW_US  = 2,
   parameter int TRIG_HIGH_US = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   uoas_req_if.sink                    req,
   uoas_rsp_if.source                  rsp,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [uoas_pkg::ADDR_W-1:0] paddr,
   input  logic [uoas_pkg::DATA_W-1:0] pwdata,
   output logic [uoas_pkg::DATA_W-1:0] prdata,
   output logic                        pready
);
   import uoas_pkg::*;

   localparam int TRIG_MAX  = (TRIG_LOW_US > TRIG_HIGH_US) ? TRIG_LOW_US : TRIG_HIGH_US;
   localparam int COUNT_MAX = (TICKS_PER_MS > TRIG_MAX) ? TICKS_PER_MS : TRIG_MAX;
   localparam int MICRO_W   = $clog2(COUNT_MAX + 1);

   cfg_type cfg;
   rsp_type result;
   logic    in_valid_ff, in_valid_in;
   logic    in_echo_ff;
   logic    out_valid_ff, out_valid_in;
   logic    fire;
   logic    req_take;

   // pipeline handshake
   assign fire      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || fire;
   assign req_take  = req.valid && req.ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
      if (fire) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_echo_ff <= req.echo_level;
      end
   end

   uoas_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   uoas_core #(
      .TICKS_PER_MS (TICKS_PER_MS),
      .TRIG_LOW_US  (TRIG_LOW_US),
      .TRIG_HIGH_US (TRIG_HIGH_US),
      .MICRO_W      (MICRO_W)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .echo_level (in_echo_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign rsp.valid         = out_valid_ff;
   assign rsp.trigger       = result.trigger;
   assign rsp.left_forward  = result.left_forward;
   assign rsp.left_reverse  = result.left_reverse;
   assign rsp.right_forward = result.right_forward;
   assign rsp.right_reverse = result.right_reverse;
   assign rsp.measure_done  = result.measure_done;
   assign rsp.distance_q8   = result.distance_q8;
endmodule

// File: dv/ultrasonic_obstacle_avoid_sequencer_tb.sv
`timescale 1ns / 1ps
module ultrasonic_obstacle_avoid_sequencer_tb;
   import uoas_pkg::*;

   localparam int TICKS_PER_MS  = 1000;
   localparam int TRIG_LOW_US   = 2;
   localparam int TRIG_HIGH_US  = 10;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_TICKS   = 120;
   localparam int RANDOM_PHASES = 4;

   typedef enum logic [2:0] {
      RANGE_TRIG_LOW  = 3'd0,
      RANGE_TRIG_HIGH = 3'd1,
      RANGE_WAIT_RISE = 3'd2,
      RANGE_MEASURE   = 3'd3,
      RANGE_STOP      = 3'd4,
      RANGE_TURN      = 3'd5,
      RANGE_PAUSE     = 3'd6
   } ranging_phase_type;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;
   logic              calm;

   uoas_req_if req_if ();
   uoas_rsp_if rsp_if ();

   ultrasonic_obstacle_avoid_sequencer #(
      .TICKS_PER_MS (TICKS_PER_MS),
      .TRIG_LOW_US  (TRIG_LOW_US),
      .TRIG_HIGH_US (TRIG_HIGH_US)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if.sink),
      .rsp     (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // echo levels waiting to be driven, and tick outputs waiting to come back
   logic    echo_ticks_q[$];
   rsp_type tick_results_q[$];
   int      ticks_queued   = 0;
   int      ticks_accepted = 0;
   int      failures       = 0;
   int      stall_cycles   = 0;

   // sequencer mirror
   cfg_type           cfg_q   = '{threshold_cm: THRESH_RST, stop_ms: STOP_RST,
                                  turn_ms: TURN_RST, pause_ms: PAUSE_RST};
   ranging_phase_type phase_q = RANGE_TRIG_LOW;
   logic [9:0]        micro_q = '0;
   logic [15:0]       milli_q = '0;
   logic [15:0]       width_q = '0;
   logic [3:0]        lines_q = LINES_STOP;
   logic [DIST_W-1:0] dist_q  = '0;

   function automatic void enter_phase(ranging_phase_type p);
      phase_q = p;
      micro_q = '0;
      milli_q = '0;
   endfunction

   // one tick of a millisecond wait, true once the limit is reached
   function automatic logic ms_wait_done(logic [15:0] limit_ms);
      micro_q = micro_q + 10'd1;
      if (micro_q >= TICKS_PER_MS) begin
         micro_q = '0;
         milli_q = milli_q + 16'd1;
      end
      return milli_q >= limit_ms;
   endfunction

   // outputs of one microsecond tick, advancing the mirror
   function automatic rsp_type advance_tick(logic echo);
      rsp_type r;
      logic    done;
      done = 1'b0;
      r.trigger = (phase_q == RANGE_TRIG_HIGH);
      {r.right_reverse, r.right_forward, r.left_reverse, r.left_forward} = lines_q;
      case (phase_q)
         RANGE_TRIG_LOW: begin
            micro_q = micro_q + 10'd1;
            if (micro_q >= TRIG_LOW_US) enter_phase(RANGE_TRIG_HIGH);
         end
         RANGE_TRIG_HIGH: begin
            micro_q = micro_q + 10'd1;
            if (micro_q >= TRIG_HIGH_US) enter_phase(RANGE_WAIT_RISE);
         end
         RANGE_WAIT_RISE: begin
            if (echo) begin
               width_q = 16'd1;
               enter_phase(RANGE_MEASURE);
            end
         end
         RANGE_MEASURE: begin
            if (echo) begin
               if (width_q != 16'hFFFF) width_q = width_q + 16'd1;
            end else begin
               dist_q = DIST_W'((32'(width_q) * 32'd1124) >> 8);
               done = 1'b1;
               if (32'(dist_q) > (32'(cfg_q.threshold_cm) << 8)) begin
                  lines_q = LINES_FORWARD;
                  enter_phase(RANGE_PAUSE);
               end else begin
                  lines_q = LINES_STOP;
                  enter_phase(RANGE_STOP);
               end
            end
         end
         RANGE_STOP: begin
            if (ms_wait_done(cfg_q.stop_ms)) begin
               lines_q = LINES_TURN_RIGHT;
               enter_phase(RANGE_TURN);
            end
         end
         RANGE_TURN: begin
            if (ms_wait_done(cfg_q.turn_ms)) begin
               lines_q = LINES_STOP;
               enter_phase(RANGE_PAUSE);
            end
         end
         RANGE_PAUSE: begin
            if (ms_wait_done(cfg_q.pause_ms)) enter_phase(RANGE_TRIG_LOW);
         end
         default: enter_phase(RANGE_TRIG_LOW);
      endcase
      r.measure_done = done;
      r.distance_q8  = dist_q;
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] mirror_value(logic [1:0] idx);
      case (idx)
         REG_THRESHOLD: return DATA_W'(cfg_q.threshold_cm);
         REG_STOP:      return DATA_W'(cfg_q.stop_ms);
         REG_TURN:      return DATA_W'(cfg_q.turn_ms);
         default:       return DATA_W'(cfg_q.pause_ms);
      endcase
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned seen);
      if (want != seen) begin
         failures++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
   endtask

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid      <= 1'b0;
         req_if.echo_level <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (echo_ticks_q.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
            req_if.valid      <= 1'b1;
            req_if.echo_level <= echo_ticks_q.pop_front();
         end else begin
            req_if.valid      <= 1'b0;
            req_if.echo_level <= 1'($urandom_range(1));
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else rsp_if.ready <= calm || ($urandom_range(99) >= 28);
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            tick_results_q.push_back(advance_tick(req_if.echo_level));
            ticks_accepted++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            seen = {rsp_if.trigger, rsp_if.left_forward, rsp_if.left_reverse,
                    rsp_if.right_forward, rsp_if.right_reverse, rsp_if.measure_done,
                    rsp_if.distance_q8};
            if (tick_results_q.size() == 0) begin
               failures++;
               $display("%0t ns: unexpected result, expected none, actual %h", $time, seen);
            end else begin
               want = tick_results_q.pop_front();
               check_field("trigger", want.trigger, seen.trigger);
               check_field("left_forward", want.left_forward, seen.left_forward);
               check_field("left_reverse", want.left_reverse, seen.left_reverse);
               check_field("right_forward", want.right_forward, seen.right_forward);
               check_field("right_reverse", want.right_reverse, seen.right_reverse);
               check_field("measure_done", want.measure_done, seen.measure_done);
               check_field("distance_q8", want.distance_q8, seen.distance_q8);
            end
         end
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
         stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
         $display("ultrasonic_obstacle_avoid_sequencer_tb failed");
         $finish;
      end else
         stall_cycles <= stall_cycles + 1;
   end

   task automatic csr_access(input logic wr, input logic [1:0] idx,
                             input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // write a register, mirror it, and read it back
   task automatic set_register(logic [1:0] idx, int unsigned value);
      logic [DATA_W-1:0] got;
      csr_access(1'b1, idx, DATA_W'(value), got);
      case (idx)
         REG_THRESHOLD: cfg_q.threshold_cm = THRESH_W'(value);
         REG_STOP:      cfg_q.stop_ms      = MS_W'(value);
         REG_TURN:      cfg_q.turn_ms      = MS_W'(value);
         default:       cfg_q.pause_ms     = MS_W'(value);
      endcase
      csr_access(1'b0, idx, '0, got);
      check_field("register readback", mirror_value(idx), got);
   endtask

   task automatic push_ticks(logic level, int count);
      repeat (count) begin
         echo_ticks_q.push_back(level);
         ticks_queued++;
      end
   endtask

   // low gap, echo pulse, then the falling tick that ends the measurement
   task automatic push_pulse(int gap, int width);
      push_ticks(1'b0, gap);
      push_ticks(1'b1, width);
      push_ticks(1'b0, 1);
   endtask

   // block has taken every request and returned every result
   task automatic wait_idle();
      while (ticks_accepted != ticks_queued || tick_results_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic int unsigned pick_ms();
      if ($urandom_range(99) < 88) return 0;
      return $urandom_range(1, 2);
   endfunction

   // stimulus
   initial begin
      logic [DATA_W-1:0] got;
      int unsigned       thr;
      int                boundary;
      int                w;
      int                start;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      calm    = 1'b0;
      reset   = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values of the registers
      for (int i = 0; i < 4; i++) begin
         csr_access(1'b0, 2'(i), '0, got);
         check_field("register reset value", mirror_value(2'(i)), got);
      end

      // trigger sequence, then an echo that never rises
      push_ticks(1'b0, 20);
      wait_idle();

      // long echo under the top threshold, quick stop and turn, then a long pause
      set_register(REG_THRESHOLD, 1023);
      set_register(REG_STOP, 0);
      set_register(REG_TURN, 0);
      set_register(REG_PAUSE, 65535);
      push_ticks(1'b1, 200);
      push_ticks(1'b0, 9);
      wait_idle();

      // pause shortened while it is running
      set_register(REG_PAUSE, 0);
      push_ticks(1'b0, 3);
      wait_idle();

      // zero threshold: shortest echo drives forward
      set_register(REG_THRESHOLD, 0);
      set_register(REG_STOP, 65535);
      set_register(REG_TURN, 65535);
      push_pulse(16, 1);
      push_pulse(16, 3);
      wait_idle();

      // obstacle: long stop, then long turn, each cut short
      set_register(REG_THRESHOLD, 1023);
      push_pulse(16, 5);
      push_ticks(1'b0, 6);
      wait_idle();
      set_register(REG_STOP, 0);
      push_ticks(1'b0, 5);
      wait_idle();
      set_register(REG_TURN, 0);
      push_ticks(1'b0, 4);
      wait_idle();

      // one millisecond stop runs to completion through the tick wrap, no idling
      set_register(REG_STOP, 1);
      calm = 1'b1;
      push_pulse(14, 2);
      push_ticks(1'b0, 1010);
      wait_idle();
      calm = 1'b0;

      // random ranging cycles around the decision boundary, with some noise
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         case ($urandom_range(9)) inside
            0:       thr = $urandom_range(0, 1023);
            1, 2:    thr = $urandom_range(4, 12);
            default: thr = $urandom_range(0, 3);
         endcase
         set_register(REG_THRESHOLD, thr);
         set_register(REG_STOP, pick_ms());
         set_register(REG_TURN, pick_ms());
         set_register(REG_PAUSE, pick_ms());
         boundary = int'((thr * 65536) / 1124);
         start = ticks_queued;
         while (ticks_queued - start < PHASE_TICKS) begin
            if ($urandom_range(99) < 85) begin
               if (boundary <= 800 && $urandom_range(1) == 1) begin
                  w = boundary + int'($urandom_range(4)) - 2;
                  if (w < 1) w = 1;
               end else
                  w = $urandom_range(1, 120);
               push_pulse($urandom_range(12, 22), w);
            end else
               repeat ($urandom_range(1, 8)) push_ticks(1'($urandom_range(1)), 1);
         end
      end

      wait_idle();
      calm = 1'b0;
      repeat (5) @(posedge clock);
      if (failures == 0)
         $display("ultrasonic_obstacle_avoid_sequencer_tb passed");
      else
         $display("ultrasonic_obstacle_avoid_sequencer_tb failed");
      $finish;
   end

endmodule
